// ===== src/keypad_led_preset_controller_macros.svh =====
// Assertion helpers for the keypad preset controller.
`ifndef KEYPAD_LED_PRESET_CONTROLLER_MACROS_SVH
`define KEYPAD_LED_PRESET_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

`define KLPC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("klpc: same-cycle check failed");

`define KLPC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("klpc: next-cycle check failed");

`else

`define KLPC_ASSERT_IMP(lbl, ante, cons)

`define KLPC_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

// ===== src/klpc_pkg.sv =====
package klpc_pkg;

  localparam int unsigned NumPresetsDef = 9;
  localparam int unsigned TableMax      = 9;

  localparam logic [7:0] KeyOne   = 8'h31;
  localparam logic [7:0] KeyNine  = 8'h39;
  localparam logic [7:0] KeyZero  = 8'h30;
  localparam logic [7:0] KeyEnter = 8'h0d;
  localparam logic [7:0] KeyA     = 8'h61;
  localparam logic [7:0] KeyC     = 8'h63;
  localparam logic [7:0] KeyPlus  = 8'h2b;
  localparam logic [7:0] KeyMinus = 8'h2d;

  localparam logic [6:0] LevelStep = 7'd10;
  localparam logic [6:0] MaxLevel  = 7'd100;

  localparam logic [1:0] ColGreen  = 2'd0;
  localparam logic [1:0] ColYellow = 2'd1;
  localparam logic [1:0] ColRed    = 2'd2;

  localparam logic [1:0] PhCodeRun    = 2'd0;
  localparam logic [1:0] PhCodeSlot   = 2'd1;
  localparam logic [1:0] PhCodeColour = 2'd2;
  localparam logic [1:0] PhCodeAdjust = 2'd3;

  typedef enum logic [3:0] {
    PH_RUN    = 4'b0001,
    PH_SLOT   = 4'b0010,
    PH_COLOUR = 4'b0100,
    PH_ADJUST = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [1:0] colour;
    logic [6:0] level;
  } preset_t;

  function automatic logic [6:0] clamp_level(input logic [6:0] lvl);
    clamp_level = (lvl > MaxLevel) ? MaxLevel : lvl;
  endfunction

  function automatic preset_t preset_init(input int unsigned idx);
    preset_t p;
    case (idx)
      0:       p = '{colour: ColGreen,  level: clamp_level(7'd10)};
      1:       p = '{colour: ColGreen,  level: clamp_level(7'd40)};
      2:       p = '{colour: ColGreen,  level: clamp_level(7'd100)};
      3:       p = '{colour: ColYellow, level: clamp_level(7'd10)};
      4:       p = '{colour: ColYellow, level: clamp_level(7'd40)};
      5:       p = '{colour: ColYellow, level: clamp_level(7'd100)};
      6:       p = '{colour: ColRed,    level: clamp_level(7'd10)};
      7:       p = '{colour: ColRed,    level: clamp_level(7'd40)};
      default: p = '{colour: ColRed,    level: clamp_level(7'd100)};
    endcase
    preset_init = p;
  endfunction

endpackage

// ===== src/keypad_led_preset_controller.sv =====
// Keypad preset lamp controller. Each input word carries one key code; each
// accepted key produces exactly one output word with the green, yellow and
// red PWM duty levels, the edit phase and the level under edit, all as they
// stand after that key. Keys are taken one per cycle: the key is decoded and
// applied to the state registers in the cycle it is accepted, and the result
// is presented from those registers on the next cycle. The input is stalled
// only while a result is waiting and the output side is not ready. The
// preset table lives in flip-flops and is loaded with its start-up presets
// at reset.
`include "keypad_led_preset_controller_macros.svh"

module keypad_led_preset_controller #(
  parameter int unsigned NUM_PRESETS = klpc_pkg::NumPresetsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] key_code
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata    // [6:0] green_duty, [13:7] yellow_duty,
                                      // [20:14] red_duty, [22:21] phase,
                                      // [29:23] edit_level, [31:30] zero
);

  localparam int unsigned SlotW = (NUM_PRESETS > 1) ? $clog2(NUM_PRESETS) : 1;

  klpc_pkg::phase_e  phase_q, phase_d;
  logic [3:0]        slot_sel_q, slot_sel_d;
  logic [1:0]        edit_colour_q, edit_colour_d;
  logic [6:0]        edit_level_q, edit_level_d;
  logic [6:0]        duty_q [3];
  logic [6:0]        duty_d [3];
  klpc_pkg::preset_t table_q [NUM_PRESETS];
  logic              out_valid_q;

  logic              in_acc;
  logic [7:0]        key;
  logic [7:0]        key_off;
  logic              key_slot_ok;
  logic [3:0]        rd_slot;
  klpc_pkg::preset_t rd_entry;
  logic              tbl_we;
  logic [7:0]        lvl_inc;
  logic [1:0]        phase_code;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign key           = s_axis_tdata;
  assign key_off       = key - klpc_pkg::KeyOne;
  assign key_slot_ok   = (key >= klpc_pkg::KeyOne) && (key <= klpc_pkg::KeyNine) &&
                         (key_off < 8'(NUM_PRESETS));
  assign rd_slot       = (phase_q == klpc_pkg::PH_RUN) ? key_off[3:0] : slot_sel_q;
  assign rd_entry      = table_q[rd_slot[SlotW-1:0]];
  assign lvl_inc       = {1'b0, edit_level_q} + {1'b0, klpc_pkg::LevelStep};

  always_comb begin
    phase_d       = phase_q;
    slot_sel_d    = slot_sel_q;
    edit_colour_d = edit_colour_q;
    edit_level_d  = edit_level_q;
    duty_d        = duty_q;
    tbl_we        = 1'b0;
    case (phase_q)
      klpc_pkg::PH_RUN: begin
        if (key_slot_ok) begin
          duty_d = '{default: 7'd0};
          case (rd_entry.colour)
            klpc_pkg::ColGreen:  duty_d[0] = rd_entry.level;
            klpc_pkg::ColYellow: duty_d[1] = rd_entry.level;
            klpc_pkg::ColRed:    duty_d[2] = rd_entry.level;
            default: ;
          endcase
        end else if (key == klpc_pkg::KeyZero) begin
          duty_d = '{default: 7'd0};
        end else if (key == klpc_pkg::KeyEnter) begin
          phase_d = klpc_pkg::PH_SLOT;
        end
      end
      klpc_pkg::PH_SLOT: begin
        if (key_slot_ok) begin
          slot_sel_d = key_off[3:0];
          phase_d    = klpc_pkg::PH_COLOUR;
        end
      end
      klpc_pkg::PH_COLOUR: begin
        if ((key >= klpc_pkg::KeyA) && (key <= klpc_pkg::KeyC)) begin
          edit_colour_d = 2'(key - klpc_pkg::KeyA);
          edit_level_d  = rd_entry.level;
          phase_d       = klpc_pkg::PH_ADJUST;
        end
      end
      klpc_pkg::PH_ADJUST: begin
        if ((key == klpc_pkg::KeyPlus) && (edit_level_q < klpc_pkg::MaxLevel)) begin
          edit_level_d = (lvl_inc > {1'b0, klpc_pkg::MaxLevel}) ?
                         klpc_pkg::MaxLevel : lvl_inc[6:0];
        end else if ((key == klpc_pkg::KeyMinus) && (edit_level_q != 7'd0)) begin
          edit_level_d = (edit_level_q > klpc_pkg::LevelStep) ?
                         (edit_level_q - klpc_pkg::LevelStep) : 7'd0;
        end else if (key == klpc_pkg::KeyEnter) begin
          tbl_we  = 1'b1;
          phase_d = klpc_pkg::PH_RUN;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= klpc_pkg::PH_RUN;
      slot_sel_q    <= 4'd0;
      edit_colour_q <= klpc_pkg::ColGreen;
      edit_level_q  <= 7'd0;
      duty_q        <= '{default: 7'd0};
      out_valid_q   <= 1'b0;
      for (int unsigned i = 0; i < NUM_PRESETS; i++) begin
        table_q[i] <= klpc_pkg::preset_init(i);
      end
    end else begin
      if (in_acc) begin
        phase_q       <= phase_d;
        slot_sel_q    <= slot_sel_d;
        edit_colour_q <= edit_colour_d;
        edit_level_q  <= edit_level_d;
        duty_q        <= duty_d;
        if (tbl_we) begin
          table_q[slot_sel_q[SlotW-1:0]] <= '{colour: edit_colour_q, level: edit_level_q};
        end
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    case (phase_q)
      klpc_pkg::PH_RUN:    phase_code = klpc_pkg::PhCodeRun;
      klpc_pkg::PH_SLOT:   phase_code = klpc_pkg::PhCodeSlot;
      klpc_pkg::PH_COLOUR: phase_code = klpc_pkg::PhCodeColour;
      klpc_pkg::PH_ADJUST: phase_code = klpc_pkg::PhCodeAdjust;
      default:             phase_code = klpc_pkg::PhCodeRun;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, edit_level_q, phase_code, duty_q[2], duty_q[1], duty_q[0]};

  `KLPC_ASSERT_IMP(a_level_bound, 1'b1, edit_level_q <= klpc_pkg::MaxLevel)
  `KLPC_ASSERT_IMP(a_slot_bound, 1'b1, slot_sel_q < 4'(NUM_PRESETS))
  `KLPC_ASSERT_IMP(a_one_lamp, 1'b1,
    $countones({duty_q[0] != 7'd0, duty_q[1] != 7'd0, duty_q[2] != 7'd0}) <= 1)
  `KLPC_ASSERT_IMP(a_stall_cause, !s_axis_tready, out_valid_q && !m_axis_tready)
  `KLPC_ASSERT_NXT(a_result_follows, in_acc, out_valid_q)

endmodule

// ===== sim/tb_keypad_led_preset_controller.sv =====
module tb_keypad_led_preset_controller;
  timeunit 1ns;
  timeprecision 1ps;

  // expected output words, computed key by key from a private copy of the state
  class duty_forecast;
    logic [1:0] mode;
    logic [3:0] slot;
    logic [1:0] colour;
    logic [6:0] level;
    logic [8:0] presets [klpc_pkg::TableMax];
    logic [6:0] duty [3];
    logic [31:0] due_words [$];
    int faults;

    function new();
      int unsigned lv;
      mode = klpc_pkg::PhCodeRun;
      slot = '0;
      colour = klpc_pkg::ColGreen;
      level = '0;
      duty = '{default: '0};
      faults = 0;
      for (int i = 0; i < klpc_pkg::TableMax; i++) begin
        lv = (i % 3 == 0) ? 10 : (i % 3 == 1) ? 40 : 100;
        if (lv > klpc_pkg::MaxLevel) lv = klpc_pkg::MaxLevel;
        presets[i][8:7] = (i < 3) ? klpc_pkg::ColGreen :
                          (i < 6) ? klpc_pkg::ColYellow : klpc_pkg::ColRed;
        presets[i][6:0] = 7'(lv);
      end
    endfunction

    function bit slot_key(logic [7:0] k, output logic [3:0] s);
      s = '0;
      if (k < klpc_pkg::KeyOne || k > klpc_pkg::KeyNine) return 0;
      if (int'(k - klpc_pkg::KeyOne) >= klpc_pkg::NumPresetsDef) return 0;
      s = 4'(k - klpc_pkg::KeyOne);
      return 1;
    endfunction

    function void fault(string msg);
      faults++;
      if (faults <= 10) $display("mismatch: %s", msg);
    endfunction

    function void take_key(logic [7:0] k);
      logic [3:0] s;
      logic [1:0] c;
      int unsigned lv;
      case (mode)
        klpc_pkg::PhCodeRun: begin
          if (slot_key(k, s)) begin
            c = presets[s][8:7];
            duty = '{default: '0};
            if (c <= klpc_pkg::ColRed) duty[c] = presets[s][6:0];
          end else if (k == klpc_pkg::KeyZero) begin
            duty = '{default: '0};
          end else if (k == klpc_pkg::KeyEnter) begin
            mode = klpc_pkg::PhCodeSlot;
          end
        end
        klpc_pkg::PhCodeSlot: begin
          if (slot_key(k, s)) begin
            slot = s;
            mode = klpc_pkg::PhCodeColour;
          end
        end
        klpc_pkg::PhCodeColour: begin
          if (k >= klpc_pkg::KeyA && k <= klpc_pkg::KeyC) begin
            colour = 2'(k - klpc_pkg::KeyA);
            level = presets[slot][6:0];
            mode = klpc_pkg::PhCodeAdjust;
          end
        end
        default: begin
          if (k == klpc_pkg::KeyPlus && level < klpc_pkg::MaxLevel) begin
            lv = level + klpc_pkg::LevelStep;
            level = (lv > klpc_pkg::MaxLevel) ? klpc_pkg::MaxLevel : 7'(lv);
          end else if (k == klpc_pkg::KeyMinus && level > 0) begin
            level = (level > klpc_pkg::LevelStep) ? level - klpc_pkg::LevelStep : '0;
          end else if (k == klpc_pkg::KeyEnter) begin
            presets[slot] = {colour, level};
            mode = klpc_pkg::PhCodeRun;
          end
        end
      endcase
      due_words.push_back({2'b00, level, mode, duty[klpc_pkg::ColRed],
                           duty[klpc_pkg::ColYellow], duty[klpc_pkg::ColGreen]});
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) fault($sformatf("%s expected %0d got %0d", name, want, got));
    endfunction

    function void match_word(logic [31:0] got);
      logic [31:0] want;
      if (due_words.size() == 0) begin
        fault($sformatf("unexpected word %h", got));
        return;
      end
      want = due_words.pop_front();
      check_field("green_duty", want[6:0], got[6:0]);
      check_field("yellow_duty", want[13:7], got[13:7]);
      check_field("red_duty", want[20:14], got[20:14]);
      check_field("phase", want[22:21], got[22:21]);
      check_field("edit_level", want[29:23], got[29:23]);
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;

  duty_forecast board = new();
  bit calm = 1'b0;
  int stall = 0;
  int n_total = 0;

  keypad_led_preset_controller uut (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata
  );

  always #10 clk_i = ~clk_i;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  always @(posedge clk_i) begin
    if (stall == 0 && !calm && $urandom_range(0, 3) == 0) stall = pick_gap();
    if (stall > 0) begin
      m_axis_tready <= 1'b0;
      stall--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.match_word(m_axis_tdata);
  end

  task automatic send_key(input logic [7:0] k);
    int gap;
    gap = (calm || $urandom_range(0, 9) < 6) ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= k;
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_key(k);
    n_total++;
  endtask

  // mostly keys that make sense in the current phase, some noise
  function automatic logic [7:0] next_key();
    int r;
    r = $urandom_range(0, 99);
    case (board.mode)
      klpc_pkg::PhCodeRun: begin
        if (r < 35) return klpc_pkg::KeyEnter;
        if (r < 75) return 8'(klpc_pkg::KeyZero + $urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
      end
      klpc_pkg::PhCodeSlot: begin
        if (r < 80) return 8'(klpc_pkg::KeyOne + $urandom_range(0, 8));
        if (r < 85) return klpc_pkg::KeyZero;
        return 8'($urandom_range(0, 255));
      end
      klpc_pkg::PhCodeColour: begin
        if (r < 80) return 8'(klpc_pkg::KeyA + $urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
      end
      default: begin
        if (r < 40) return klpc_pkg::KeyPlus;
        if (r < 75) return klpc_pkg::KeyMinus;
        if (r < 90) return klpc_pkg::KeyEnter;
        return 8'($urandom_range(0, 255));
      end
    endcase
  endfunction

  initial begin
    logic [7:0] opening [];
    int waited;
    opening = '{8'h00, 8'hff, "1", "2", "3", "4", "5", "6", "7", "8", "9",
                klpc_pkg::KeyZero, klpc_pkg::KeyEnter, klpc_pkg::KeyZero, "3", "d", "c",
                klpc_pkg::KeyPlus, klpc_pkg::KeyMinus, klpc_pkg::KeyEnter, "3",
                klpc_pkg::KeyEnter, "1", "a", klpc_pkg::KeyMinus, klpc_pkg::KeyMinus,
                klpc_pkg::KeyEnter, "1"};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (opening[i]) send_key(opening[i]);
    while (n_total < 1900) begin
      if (n_total % 150 == 0) calm = ($urandom_range(0, 3) == 0);
      send_key(next_key());
    end
    s_axis_tvalid <= 1'b0;
    calm = 1'b0;
    waited = 0;
    while (board.due_words.size() != 0 && waited < 1000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
    if (board.due_words.size() != 0)
      board.fault($sformatf("%0d words never came out", board.due_words.size()));
    if (board.faults == 0) begin
      $display("[keypad_led_preset_controller] OK");
    end else begin
      $display("[keypad_led_preset_controller] ERROR");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("[keypad_led_preset_controller] ERROR");
    $finish;
  end

endmodule
